FILE: sv/pwcd_pkg.sv
package pwcd_pkg;

  // Request kinds
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Symbol codes
  localparam logic [1:0] SYM_LOW  = 2'd0;
  localparam logic [1:0] SYM_HIGH = 2'd1;
  localparam logic [1:0] SYM_STAR = 2'd2;
  localparam logic [1:0] SYM_END  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_SHORT_MIN = 3'd0;
  localparam logic [2:0] CFG_SHORT_MAX = 3'd1;
  localparam logic [2:0] CFG_LONG_MIN  = 3'd2;
  localparam logic [2:0] CFG_LONG_MAX  = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT   = 3'd4;

  // Configuration reset values
  localparam logic [15:0] SHORT_MIN_RST = 16'h0040;
  localparam logic [15:0] SHORT_MAX_RST = 16'h0048;
  localparam logic [15:0] LONG_MIN_RST  = 16'h0084;
  localparam logic [15:0] LONG_MAX_RST  = 16'h0092;
  localparam logic [7:0]  TIMEOUT_RST   = 8'h08;

  // Measured edges per frame
  localparam int unsigned MAX_PULSES = 128;

  // Result queue sizing
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  symbol;
    logic [8:0]  whole_periods;
    logic [15:0] fraction;
    logic        last;
  } res_t;

  // Results produced by one request, in order from item[0]
  typedef struct packed {
    logic [1:0]                 n;
    res_t [MAX_RESULTS-1:0]     item;
  } push_t;

endpackage

FILE: sv/pwcd_queue.sv
module pwcd_queue
  import pwcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  res_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;
  logic [QUEUE_CW-1:0]   count_next;
  logic                  pop;

  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Room for a full burst of results, judged on the registered count only
  assign room      = (count <= QUEUE_CW'(QUEUE_DEPTH - MAX_RESULTS));

  assign count_next = count + QUEUE_CW'(push.n) - QUEUE_CW'(pop);

  // Write up to a burst of results at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (i < int'(push.n)) begin
        mem[wr_ptr + QUEUE_AW'(i)] <= push.item[i];
      end
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_AW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("result queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (count + QUEUE_CW'(push.n) <= QUEUE_CW'(QUEUE_DEPTH)))
    else $error("result queue written past its depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count_next))
    else $error("result queue count lost track");

endmodule

FILE: sv/pulse_width_capture_decoder.sv
// Pulse width decoder for on-off keyed frames. Each request is an edge capture or a timer
// overflow tick; the frame state updates in the cycle the request is taken and the results
// it causes (none to three) go into a four-entry result queue that drives the output, one
// result per cycle while the receiver does not stall. A request is taken in any cycle in
// which the queue holds at most one result, so a steady stream of requests runs at one per
// cycle while each yields one result and the receiver does not stall; requests that yield
// more results are held back, since the single output port of the queue drains them.
module pulse_width_capture_decoder
  import pwcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] capture_value,
  input  logic        pin_level,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  symbol,
  output logic [8:0]  whole_periods,
  output logic [15:0] fraction,
  output logic        last
);

  logic [15:0] short_min;
  logic [15:0] short_max;
  logic [15:0] long_min;
  logic [15:0] long_max;
  logic [7:0]  timeout_ticks;

  logic        armed;
  logic        current_level;
  logic [15:0] previous_capture;
  logic [7:0]  idle_ticks;
  logic [7:0]  sample_count;

  logic        armed_next;
  logic        current_level_next;
  logic [15:0] previous_capture_next;
  logic [7:0]  idle_ticks_next;
  logic [7:0]  sample_count_next;

  logic        accept;
  logic        room;
  push_t       push;
  res_t        out_res;

  logic [8:0]  idle_inc;
  logic [8:0]  whole;
  logic [15:0] frac;
  logic        is_short;
  logic        is_long;
  logic [8:0]  count_inc;
  logic [1:0]  lvl_sym;
  res_t        meas;
  res_t        end_res;

  assign in_stall = !room;
  assign accept   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_min     <= SHORT_MIN_RST;
      short_max     <= SHORT_MAX_RST;
      long_min      <= LONG_MIN_RST;
      long_max      <= LONG_MAX_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_MIN: short_min     <= cfg_data;
        CFG_SHORT_MAX: short_max     <= cfg_data;
        CFG_LONG_MIN:  long_min      <= cfg_data;
        CFG_LONG_MAX:  long_max      <= cfg_data;
        CFG_TIMEOUT:   timeout_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Measure the duration since the previous edge, with wrap handling
  always_comb begin
    idle_inc  = {1'b0, idle_ticks} + 9'd1;
    count_inc = {1'b0, sample_count} + 9'd1;
    whole     = {1'b0, idle_ticks};
    frac      = capture_value - previous_capture;
    if (idle_ticks != 8'd0) begin
      if (previous_capture < capture_value) begin
        whole = idle_inc;
      end else begin
        frac = 16'hFFFF - previous_capture + capture_value;
      end
    end
    is_short = (frac >= short_min) && (frac <= short_max);
    is_long  = (frac >= long_min) && (frac <= long_max);
    lvl_sym  = current_level ? SYM_HIGH : SYM_LOW;

    meas.symbol        = (is_short || is_long) ? lvl_sym : SYM_STAR;
    meas.whole_periods = whole;
    meas.fraction      = frac;
    meas.last          = 1'b0;

    end_res.symbol        = SYM_END;
    end_res.whole_periods = '0;
    end_res.fraction      = '0;
    end_res.last          = 1'b1;
  end

  // Work out the next frame state and the results of this request
  always_comb begin
    armed_next            = armed;
    current_level_next    = current_level;
    previous_capture_next = previous_capture;
    idle_ticks_next       = idle_ticks;
    sample_count_next     = sample_count;
    push.n                = 2'd0;
    push.item             = '0;

    if (accept) begin
      if (req_type == REQ_TICK) begin
        // idle_ticks never passes 255: it clears once above the timeout
        if (idle_inc > {1'b0, timeout_ticks}) begin
          push.n             = 2'd1;
          push.item[0]       = end_res;
          armed_next         = 1'b0;
          current_level_next = 1'b0;
          idle_ticks_next    = 8'd0;
          sample_count_next  = 8'd0;
        end else begin
          idle_ticks_next = idle_inc[7:0];
        end
      end else if (!armed) begin
        armed_next            = 1'b1;
        current_level_next    = pin_level;
        idle_ticks_next       = 8'd0;
        previous_capture_next = capture_value;
      end else begin
        push.item[0]          = meas;
        push.item[1]          = meas;
        push.n                = (is_long && !is_short) ? 2'd2 : 2'd1;
        current_level_next    = !current_level;
        sample_count_next     = count_inc[7:0];
        idle_ticks_next       = 8'd0;
        previous_capture_next = capture_value;
        if (count_inc >= 9'(MAX_PULSES)) begin
          push.item[push.n]  = end_res;
          push.n             = push.n + 2'd1;
          armed_next         = 1'b0;
          current_level_next = 1'b0;
          sample_count_next  = 8'd0;
        end else begin
          push.item[push.n - 2'd1].last = 1'b1;
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed            <= 1'b0;
      current_level    <= 1'b0;
      previous_capture <= 16'd0;
      idle_ticks       <= 8'd0;
      sample_count     <= 8'd0;
    end else begin
      armed            <= armed_next;
      current_level    <= current_level_next;
      previous_capture <= previous_capture_next;
      idle_ticks       <= idle_ticks_next;
      sample_count     <= sample_count_next;
    end
  end

  pwcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign symbol        = out_res.symbol;
  assign whole_periods = out_res.whole_periods;
  assign fraction      = out_res.fraction;
  assign last          = out_res.last;

  a_edge_result: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_EDGE && armed) |-> (push.n != 2'd0))
    else $error("measured edge gave no result");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !armed |-> (sample_count == 8'd0))
    else $error("sample count held outside a frame");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, sample_count} < 9'(MAX_PULSES))
    else $error("sample count reached frame limit without ending");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0 && push.item[push.n - 2'd1].symbol == SYM_END) |=> !armed)
    else $error("frame end left decoder armed");

endmodule

FILE: tb/sv/pwcd_tb_pkg.sv
package pwcd_tb_pkg;
  import pwcd_pkg::*;

  // Tracks decoder frame state and the symbols each request should produce
  class pulse_symbol_board;
    logic [15:0] short_lo;
    logic [15:0] short_hi;
    logic [15:0] long_lo;
    logic [15:0] long_hi;
    logic [7:0]  tick_limit;

    logic        frame_open;
    logic        level_now;
    logic [15:0] last_stamp;
    logic [15:0] ticks_seen;
    logic [7:0]  pulses_seen;

    res_t symbols_due[$];
    int   mismatches;
    int   requests;
    int   results;
    int   per_symbol[4];

    function new();
      short_lo   = SHORT_MIN_RST;
      short_hi   = SHORT_MAX_RST;
      long_lo    = LONG_MIN_RST;
      long_hi    = LONG_MAX_RST;
      tick_limit = TIMEOUT_RST;
      last_stamp = '0;
      close_frame();
      mismatches = 0;
      requests   = 0;
      results    = 0;
      foreach (per_symbol[i]) per_symbol[i] = 0;
    endfunction

    // Drop back to waiting for the first edge; the last timestamp is kept
    function void close_frame();
      frame_open  = 1'b0;
      level_now   = 1'b0;
      ticks_seen  = '0;
      pulses_seen = '0;
    endfunction

    function void set_register(logic [2:0] index, logic [15:0] value);
      case (index)
        CFG_SHORT_MIN: short_lo = value;
        CFG_SHORT_MAX: short_hi = value;
        CFG_LONG_MIN:  long_lo = value;
        CFG_LONG_MAX:  long_hi = value;
        CFG_TIMEOUT:   tick_limit = value[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return symbols_due.size();
    endfunction

    function void queue_symbol(logic [1:0] sym, logic [8:0] whole, logic [15:0] frac);
      res_t r;
      r.symbol        = sym;
      r.whole_periods = whole;
      r.fraction      = frac;
      r.last          = 1'b0;
      symbols_due.push_back(r);
    endfunction

    // Advance the frame by one accepted request and queue what it emits
    function void take_request(logic kind, logic [15:0] stamp, logic pin);
      res_t        r;
      int          first;
      logic [8:0]  whole;
      logic [15:0] frac;
      logic [1:0]  level_sym;
      first = symbols_due.size();
      requests++;
      if (kind == REQ_TICK) begin
        if (ticks_seen != 16'hFFFF) ticks_seen = ticks_seen + 16'd1;
        if (ticks_seen > {8'h00, tick_limit}) begin
          queue_symbol(SYM_END, '0, '0);
          close_frame();
        end
      end else if (!frame_open) begin
        frame_open = 1'b1;
        level_now  = pin;
        ticks_seen = '0;
        last_stamp = stamp;
      end else begin
        // Duration since the previous edge, wrap arithmetic kept as the block does it
        whole = ticks_seen[8:0];
        if (ticks_seen == 16'd0) begin
          frac = stamp - last_stamp;
        end else if (last_stamp < stamp) begin
          whole = whole + 9'd1;
          frac  = stamp - last_stamp;
        end else begin
          frac = 16'hFFFF - last_stamp + stamp;
        end
        level_sym = level_now ? SYM_HIGH : SYM_LOW;
        // Short range wins where the ranges overlap
        if (frac >= short_lo && frac <= short_hi) begin
          queue_symbol(level_sym, whole, frac);
        end else if (frac >= long_lo && frac <= long_hi) begin
          queue_symbol(level_sym, whole, frac);
          queue_symbol(level_sym, whole, frac);
        end else begin
          queue_symbol(SYM_STAR, whole, frac);
        end
        level_now   = ~level_now;
        pulses_seen = pulses_seen + 8'd1;
        ticks_seen  = '0;
        last_stamp  = stamp;
        if (pulses_seen >= MAX_PULSES) begin
          queue_symbol(SYM_END, '0, '0);
          close_frame();
        end
      end
      // Flag the final symbol of this request
      if (symbols_due.size() > first) begin
        r      = symbols_due.pop_back();
        r.last = 1'b1;
        symbols_due.push_back(r);
      end
    endfunction

    task log_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    // Compare one delivered symbol against the oldest one due
    task match_symbol(res_t got);
      res_t want;
      results++;
      if (symbols_due.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with nothing due (sym %0d whole %0d frac %h)",
                               results, got.symbol, got.whole_periods, got.fraction));
        return;
      end
      want = symbols_due.pop_front();
      per_symbol[want.symbol]++;
      if (got.symbol !== want.symbol)
        log_mismatch($sformatf("result %0d: symbol %0d, want %0d",
                               results, got.symbol, want.symbol));
      if (got.whole_periods !== want.whole_periods)
        log_mismatch($sformatf("result %0d: whole_periods %0d, want %0d",
                               results, got.whole_periods, want.whole_periods));
      if (got.fraction !== want.fraction)
        log_mismatch($sformatf("result %0d: fraction %h, want %h",
                               results, got.fraction, want.fraction));
      if (got.last !== want.last)
        log_mismatch($sformatf("result %0d: last %0d, want %0d",
                               results, got.last, want.last));
    endtask
  endclass

endpackage

FILE: tb/sv/pulse_width_capture_decoder_tb.sv
module pulse_width_capture_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwcd_pkg::*;
  import pwcd_tb_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 1000;
  localparam int LONG_HOLD    = 80;
  localparam int IDLE_PCT     = 10;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [15:0] capture_value;
  logic        pin_level;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  symbol;
  logic [8:0]  whole_periods;
  logic [15:0] fraction;
  logic        last;

  pulse_symbol_board board;
  bit        idle_on;
  int        holds_asked;
  int        holds_done;
  int        hold_left;
  int        sent;
  bit [31:0] timer_now;

  pulse_width_capture_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .capture_value (capture_value),
    .pin_level     (pin_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .symbol        (symbol),
    .whole_periods (whole_periods),
    .fraction      (fraction),
    .last          (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random single-cycle stalls, plus a long hold when one is asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done = holds_done + 1;
      hold_left  = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Check delivered symbols first, then note the request taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        board.match_symbol(res_t'({symbol, whole_periods, fraction, last}));
      if (in_valid && !in_stall)
        board.take_request(req_type, capture_value, pin_level);
    end
  end

  // End the run if nothing moves on either channel for too long
  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stale = 0;
      else stale++;
    end
    $display("no request moved for %0d cycles", STALL_LIMIT);
    $display("pulse_width_capture_decoder_tb: errors");
    $finish;
  end

  // Offer one request, with an occasional gap of junk payload, and hold until taken
  task automatic send_request(input logic kind, input logic [15:0] stamp, input logic pin);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < IDLE_PCT) ? 1 : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid      <= 1'b0;
      req_type      <= 1'($urandom);
      capture_value <= 16'($urandom);
      pin_level     <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= kind;
    capture_value <= stamp;
    pin_level     <= pin;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_request(REQ_TICK, 16'($urandom), 1'($urandom));
  endtask

  // Drop valid and wait until every symbol due has come out, then let the block settle
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_register(index, value);
  endtask

  task automatic set_ranges(input logic [15:0] s_lo, input logic [15:0] s_hi,
                            input logic [15:0] l_lo, input logic [15:0] l_hi,
                            input logic [7:0] limit);
    write_register(CFG_SHORT_MIN, s_lo);
    write_register(CFG_SHORT_MAX, s_hi);
    write_register(CFG_LONG_MIN, l_lo);
    write_register(CFG_LONG_MAX, l_hi);
    write_register(CFG_TIMEOUT, {8'h00, limit});
  endtask

  function automatic logic [15:0] span_in(input logic [15:0] lo, input logic [15:0] hi);
    if (lo <= hi) return 16'($urandom_range(32'(hi), 32'(lo)));
    return 16'($urandom);
  endfunction

  // One frame off a free-running timer: arm edge, pulses with ticks on each wrap,
  // then optionally enough ticks to time the frame out
  task automatic send_frame(input int pulses, input bit close_out);
    int          pick;
    int          wraps;
    logic [15:0] span;
    bit [31:0]   next_time;
    timer_now = timer_now + $urandom_range(0, 65535);
    send_request(REQ_EDGE, timer_now[15:0], 1'($urandom));
    repeat (pulses) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        span = span_in(board.short_lo, board.short_hi);
      end else if (pick < 70) begin
        span = span_in(board.long_lo, board.long_hi);
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: span = board.short_lo - 16'd1;
          1: span = board.short_hi + 16'd1;
          2: span = board.long_lo - 16'd1;
          default: span = board.long_hi + 16'd1;
        endcase
      end else begin
        span = 16'($urandom);
      end
      wraps = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 3) : 0;
      next_time = timer_now + {wraps[15:0], span};
      send_ticks(int'(next_time[31:16] - timer_now[31:16]));
      send_request(REQ_EDGE, next_time[15:0], 1'($urandom));
      timer_now = next_time;
    end
    if (close_out) send_ticks(int'(board.tick_limit) + 1);
  endtask

  // Mostly well-formed frames, the rest raw noise requests
  task automatic run_phase(input int quota);
    int start;
    start = sent;
    while (sent - start < quota) begin
      if ($urandom_range(0, 99) < 20)
        repeat ($urandom_range(1, 5)) send_request(1'($urandom), 16'($urandom), 1'($urandom));
      else
        send_frame($urandom_range(1, 16), board.tick_limit <= 16 && $urandom_range(0, 99) < 60);
    end
    quiesce();
  endtask

  initial begin
    logic [15:0] s_lo;
    logic [15:0] l_lo;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SHORT_MIN;
    cfg_data      = '0;
    in_valid      = 1'b0;
    req_type      = REQ_EDGE;
    capture_value = '0;
    pin_level     = 1'b0;
    out_stall     = 1'b0;
    idle_on       = 1'b1;
    holds_asked   = 0;
    holds_done    = 0;
    hold_left     = 0;
    sent          = 0;
    timer_now     = '0;
    board         = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: default ranges, short timeout
    write_register(CFG_TIMEOUT, 16'h0002);
    send_ticks(3);                              // ticks with no frame end one alone
    send_request(REQ_EDGE, 16'hFFC0, 1'b1);     // arm high
    send_request(REQ_EDGE, 16'h0000, 1'b0);     // short min across a timer wrap
    send_request(REQ_EDGE, 16'h0048, 1'b1);     // short max
    send_request(REQ_EDGE, 16'h0091, 1'b0);     // just above short
    send_request(REQ_EDGE, 16'h0115, 1'b1);     // long min, double symbol
    send_request(REQ_EDGE, 16'h01A7, 1'b0);     // long max, double symbol
    send_request(REQ_EDGE, 16'h023A, 1'b1);     // just above long
    send_request(REQ_EDGE, 16'h02BD, 1'b0);     // just below long
    send_request(REQ_EDGE, 16'h02FC, 1'b1);     // just below short
    send_ticks(1);
    send_request(REQ_EDGE, 16'h0400, 1'b0);     // tick, later stamp
    send_ticks(1);
    send_request(REQ_EDGE, 16'h0100, 1'b1);     // tick, earlier stamp
    send_ticks(1);
    send_request(REQ_EDGE, 16'h0100, 1'b0);     // tick, same stamp
    send_ticks(2);
    send_request(REQ_EDGE, 16'hFFFF, 1'b1);
    send_ticks(3);                              // time the frame out
    quiesce();

    // Zero timeout: every tick ends the frame
    write_register(CFG_TIMEOUT, 16'h0000);
    run_phase(8);

    // Reset values, one full-length frame with no idling on either side
    idle_on = 1'b0;
    set_ranges(SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST, TIMEOUT_RST);
    send_frame(MAX_PULSES + $urandom_range(0, 3), 1'b1);
    quiesce();
    idle_on = 1'b1;

    // Random ranges, with the receiver held off long enough to back up the input
    s_lo = 16'($urandom_range(0, 16'hF000));
    l_lo = 16'($urandom_range(0, 16'hF000));
    set_ranges(s_lo, s_lo + 16'($urandom_range(0, 16'h0FFF)),
               l_lo, l_lo + 16'($urandom_range(0, 16'h0FFF)), 8'($urandom_range(1, 12)));
    holds_asked++;
    run_phase(24);

    // Single-value ranges at both ends, shortest nonzero timeout
    set_ranges(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'd1);
    run_phase(8);

    // Longest timeout: close the frame first, then reach the widest whole count
    send_ticks(int'(board.tick_limit) + 1);
    quiesce();
    set_ranges(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd255);
    send_request(REQ_EDGE, 16'h0010, 1'b0);
    send_ticks(255);
    send_request(REQ_EDGE, 16'h0020, 1'b1);
    send_frame(6, 1'b0);
    quiesce();

    // Overlapping ranges: the short class must win
    set_ranges(16'h0100, 16'h0200, 16'h0180, 16'h0300, 8'd5);
    run_phase(8);

    // Empty ranges: everything unclassified
    set_ranges(16'h0200, 16'h01FF, 16'hFFFF, 16'h0000, 8'd4);
    holds_asked++;
    run_phase(8);

    $display("covered %0d requests over eight register settings, incl. long receiver holds",
             board.requests);
    $display("symbols checked: %0d low, %0d high, %0d star, %0d end of frame",
             board.per_symbol[SYM_LOW], board.per_symbol[SYM_HIGH],
             board.per_symbol[SYM_STAR], board.per_symbol[SYM_END]);
    if (board.mismatches == 0)
      $display("pulse_width_capture_decoder_tb: clean");
    else
      $display("pulse_width_capture_decoder_tb: errors");
    $finish;
  end

endmodule
